### sv/ptd_pkg.sv
// shared constants, types and register codes for the peak/trough detector
// no dependencies; imported by peak_trough_detector, ptd_freq_unit and the bench
package ptd_pkg;

    localparam int RING_DEPTH = 8;
    localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);
    localparam int CNT_W      = 16;
    localparam int RATE_W     = 16;
    localparam int SUM_W      = CNT_W + FILL_W;
    localparam int NUM_W      = RATE_W + 4 + FILL_W;
    localparam int FREQ_W     = 20;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

    localparam logic [CNT_W-1:0]  RELEASE_COUNT = 16'd500;
    localparam logic [CNT_W-1:0]  COUNT_MAX     = '1;
    localparam logic [FREQ_W-1:0] FREQ_MAX      = '1;

    typedef enum logic [1:0] {
        CFG_MIN_INTERVAL = 2'd0,
        CFG_EVENT_ENABLE = 2'd1,
        CFG_EVENT_LINE   = 2'd2,
        CFG_SAMPLE_RATE  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic              start;
        logic [FILL_W-1:0] filled;
        logic [RATE_W-1:0] rate;
    } freq_req_t;

    typedef struct packed {
        logic              done;
        logic [FREQ_W-1:0] freq;
    } freq_rsp_t;

endpackage

### sv/peak_trough_detector.sv
// top level of the peak/trough detector: slope tracking, interval ring,
// output register; depends on ptd_pkg, ptd_ram and ptd_freq_unit
//
// usage:
//   input stream: one signed 16-bit sample per transfer on s_tdata, s_tuser
//   high negates the sample so troughs are found instead of peaks.
//   output stream: exactly one result transfer per input transfer, in order,
//   carrying the peak and release pulses, the event channel and the held
//   frequency estimate (1/16 Hz units).
//   config: cfg_we writes cfg_data into register cfg_index (0 min_interval,
//   1 event_enable, 2 event_line, 3 sample_rate); write only while idle.
// flow:
//   a sample without a peak passes from S_IDLE to S_EMIT and is loaded into
//   the result register from S_EMIT once that register is free.
//   a sample with a peak runs the estimator: it reads each stored interval
//   from the ring (registered read), multiplies, runs a restoring divide over
//   the 24 quotient bits at depth 8, saturates and hands the estimate back;
//   a zero numerator or sum skips the divide. the result then goes via S_EMIT.
//   s_tready is low while an item is in work; one item at a time.
// reset: counters, slope state, ring fill and estimate clear to zero and the
//   registers take their defaults. a stalled receiver holds the result in
//   the output register; the next item is taken and worked meanwhile and
//   waits only for the register to drain.
module peak_trough_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] sample
    input  logic        s_tuser,    // [0] trough_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [0] peak_pulse, [1] release_pulse,
                                    // [5:2] event_channel, [25:6] frequency_estimate
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ptd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        min_interval_reg;
    logic                    event_enable_reg;
    logic [3:0]              event_line_reg;
    logic [RATE_W-1:0]       sample_rate_reg;
    logic signed [16:0]      prev_reg;
    logic                    rising_reg;
    logic [CNT_W-1:0]        since_reg;
    logic [IDX_W-1:0]        wr_idx_reg;
    logic [FILL_W-1:0]       filled_reg;
    logic                    pend_peak_reg;
    logic                    pend_release_reg;
    logic                    m_tvalid_reg;
    logic [31:0]             m_tdata_reg;

    logic                    accept;
    logic signed [16:0]      s_raw;
    logic signed [16:0]      s_val;
    logic                    is_rise;
    logic                    is_peak;
    logic                    is_release;
    logic [CNT_W-1:0]        since_inc;
    logic [IDX_W-1:0]        wr_idx_next;
    logic [FILL_W-1:0]       filled_next;
    logic                    out_free;
    logic [IDX_W-1:0]        rd_addr;
    logic [CNT_W-1:0]        rd_data;
    freq_req_t               req;
    freq_rsp_t               rsp;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_raw = $signed({s_tdata[15], s_tdata});
    assign s_val = s_tuser ? -s_raw : s_raw;

    assign since_inc  = (since_reg == COUNT_MAX) ? since_reg : since_reg + 1'b1;
    assign is_rise    = (s_val > prev_reg) && !rising_reg;
    assign is_peak    = !is_rise && (s_val < prev_reg) && rising_reg
                        && (since_reg >= min_interval_reg);
    assign is_release = !is_rise && !is_peak && (since_inc == RELEASE_COUNT)
                        && (since_reg != RELEASE_COUNT);

    assign wr_idx_next = (wr_idx_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    assign filled_next = (filled_reg < FILL_W'(RING_DEPTH)) ? filled_reg + 1'b1 : filled_reg;

    assign req.start  = accept && is_peak;
    assign req.filled = filled_next;
    assign req.rate   = sample_rate_reg;

    ptd_ram #(
        .WIDTH (CNT_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (accept && is_peak),
        .waddr (wr_idx_reg),
        .wdata (since_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    ptd_freq_unit u_freq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rsp     (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= 16'd1500;
            event_enable_reg <= 1'b1;
            event_line_reg   <= 4'd3;
            sample_rate_reg  <= 16'd30000;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                CFG_EVENT_ENABLE: event_enable_reg <= cfg_data[0];
                CFG_EVENT_LINE:   event_line_reg   <= cfg_data[3:0];
                CFG_SAMPLE_RATE:  sample_rate_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            prev_reg         <= '0;
            rising_reg       <= 1'b0;
            since_reg        <= '0;
            wr_idx_reg       <= '0;
            filled_reg       <= '0;
            pend_peak_reg    <= 1'b0;
            pend_release_reg <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
        end
        else
        begin
            if (state_reg == S_EMIT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        prev_reg         <= s_val;
                        pend_peak_reg    <= is_peak && event_enable_reg;
                        pend_release_reg <= is_release && event_enable_reg;
                        if (is_rise)
                        begin
                            rising_reg <= 1'b1;
                            since_reg  <= since_inc;
                            state_reg  <= S_EMIT;
                        end
                        else if (is_peak)
                        begin
                            rising_reg <= 1'b0;
                            since_reg  <= '0;
                            wr_idx_reg <= wr_idx_next;
                            filled_reg <= filled_next;
                            state_reg  <= S_CALC;
                        end
                        else
                        begin
                            since_reg <= since_inc;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_CALC:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg  <= {6'b0, rsp.freq, event_line_reg,
                                         pend_release_reg, pend_peak_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/ptd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ptd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/ptd_freq_unit.sv
// frequency estimator: sums the stored intervals, scales the sample rate and
// runs a restoring divide one quotient bit per cycle; depends on ptd_pkg
module ptd_freq_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ptd_pkg::freq_req_t           req,
    output logic [ptd_pkg::IDX_W-1:0]    rd_addr,
    input  logic [ptd_pkg::CNT_W-1:0]    rd_data,
    output ptd_pkg::freq_rsp_t           rsp
);
    import ptd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [FILL_W-1:0]       filled_reg;
    logic [RATE_W-1:0]       rate_reg;
    logic [FILL_W-1:0]       k_reg;
    logic                    rd_pend_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [NUM_W-1:0]        quo_reg;
    logic [SUM_W-1:0]        rem_reg;
    logic [DIV_CNT_W-1:0]    step_reg;
    logic [FREQ_W-1:0]       freq_reg;
    logic                    done_reg;

    logic [RATE_W+FILL_W-1:0] prod;
    logic [NUM_W-1:0]         num;
    logic [SUM_W:0]           rem_shift;
    logic [SUM_W:0]           diff;
    logic                     fits;

    assign prod      = rate_reg * filled_reg;
    assign num       = {prod, 4'b0000};
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign diff      = rem_shift - {1'b0, sum_reg};
    assign fits      = !diff[SUM_W];
    assign rd_addr   = k_reg[IDX_W-1:0];

    assign rsp.done = done_reg;
    assign rsp.freq = freq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            filled_reg  <= '0;
            rate_reg    <= '0;
            k_reg       <= '0;
            rd_pend_reg <= 1'b0;
            sum_reg     <= '0;
            quo_reg     <= '0;
            rem_reg     <= '0;
            step_reg    <= '0;
            freq_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (req.start)
                    begin
                        filled_reg  <= req.filled;
                        rate_reg    <= req.rate;
                        k_reg       <= '0;
                        rd_pend_reg <= 1'b0;
                        sum_reg     <= '0;
                        state_reg   <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    done_reg <= 1'b0;
                    // read data follows the address in the next cycle
                    if (rd_pend_reg)
                    begin
                        sum_reg <= sum_reg + SUM_W'(rd_data);
                    end
                    if (k_reg < filled_reg)
                    begin
                        k_reg       <= k_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        if (!rd_pend_reg)
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    quo_reg  <= num;
                    rem_reg  <= '0;
                    step_reg <= DIV_CNT_W'(NUM_W);
                    if (num == '0)
                    begin
                        freq_reg  <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (sum_reg == '0)
                    begin
                        freq_reg  <= FREQ_MAX;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        done_reg  <= 1'b0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    done_reg <= 1'b0;
                    rem_reg  <= fits ? diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];
                    quo_reg  <= {quo_reg[NUM_W-2:0], fits};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == DIV_CNT_W'(1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // saturate the quotient to the estimate width
                    freq_reg  <= (|quo_reg[NUM_W-1:FREQ_W]) ? FREQ_MAX : quo_reg[FREQ_W-1:0];
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/ptd_checker.sv
// port-level checks for the peak/trough detector, bound to the top level
// depends on peak_trough_detector ports only
module ptd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a sample is never both a peak and a release
    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("peak and release in one result");

    // one item at a time: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // a new result only appears out of work on an accepted item
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without work");

endmodule

bind peak_trough_detector ptd_checker u_ptd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/tb_top.sv
// self-checking bench for peak_trough_detector: drives sample transfers, predicts each
// result with a cycle-free model of the detector and compares every output transfer
// depends on ptd_pkg and the detector rtl only
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptd_pkg::*;

    localparam logic [15:0] RELEASE_AT  = 16'd500;
    localparam logic [15:0] SINCE_TOP   = 16'hFFFF;
    localparam logic [19:0] FREQ_TOP    = 20'hFFFFF;
    localparam int          CYCLE_LIMIT = 3000000;
    localparam int          SHOW_MAX    = 40;

    typedef struct {
        logic [15:0] smp;
        logic        trough;
    } sample_item_t;

    typedef struct {
        logic        peak;
        logic        rel_pulse;
        logic [3:0]  chan;
        logic [19:0] freq;
    } detector_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;      // [15:0] sample
    logic        s_tuser = 1'b0;    // [0] trough_mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [0] peak_pulse, [1] release_pulse,
                                    // [5:2] event_channel, [25:6] frequency_estimate
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // predictor copy of the registers
    logic [15:0] min_gap = 16'd1500;
    logic        events_on = 1'b1;
    logic [3:0]  event_chan = 4'd3;
    logic [15:0] rate_hz = 16'd30000;

    // predictor copy of the detector state
    logic signed [16:0] prev_level = '0;
    logic               rising_now = 1'b0;
    logic [15:0]        since_cnt = '0;
    logic [15:0]        interval_hist [RING_DEPTH];
    int                 wr_ptr = 0;
    int                 fill_cnt = 0;
    logic [19:0]        freq_hold = '0;

    sample_item_t  pending_samples[$];
    detector_out_t expected_outputs[$];
    sample_item_t  next_item;
    detector_out_t want;

    bit quiet = 1'b0;
    int samples_sent = 0;
    int outputs_seen = 0;
    int mismatches = 0;
    int send_gap = 0;
    int stall_left = 0;
    int cycle_count = 0;

    peak_trough_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] count_up(input logic [15:0] c);
        return (c == SINCE_TOP) ? c : c + 16'd1;
    endfunction

    // rate * 16 * filled / sum of stored intervals, saturating
    function automatic logic [19:0] estimate_frequency();
        longint unsigned total;
        longint unsigned num;
        longint unsigned q;
        total = 0;
        for (int k = 0; k < fill_cnt; k++)
            total += interval_hist[k];
        num = longint'(rate_hz) * 64'd16 * longint'(fill_cnt);
        if (num == 0)
            return '0;
        if (total == 0)
            return FREQ_TOP;
        q = num / total;
        return (q > FREQ_TOP) ? FREQ_TOP : q[19:0];
    endfunction

    function automatic void advance_detector(input logic [15:0] raw, input logic trough);
        logic signed [16:0] lvl;
        logic [15:0]        prior;
        detector_out_t      r;
        lvl = {raw[15], raw};
        if (trough)
            lvl = -lvl;
        r.peak = 1'b0;
        r.rel_pulse = 1'b0;
        if (lvl > prev_level && !rising_now)
        begin
            // a rise never raises the release pulse, even on reaching the count
            rising_now = 1'b1;
            since_cnt = count_up(since_cnt);
        end
        else if (lvl < prev_level && rising_now && since_cnt >= min_gap)
        begin
            interval_hist[wr_ptr] = since_cnt;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            if (fill_cnt < RING_DEPTH)
                fill_cnt++;
            rising_now = 1'b0;
            since_cnt = '0;
            freq_hold = estimate_frequency();
            r.peak = events_on;
        end
        else
        begin
            prior = since_cnt;
            since_cnt = count_up(since_cnt);
            if (since_cnt == RELEASE_AT && prior != RELEASE_AT)
                r.rel_pulse = events_on;
        end
        prev_level = lvl;
        r.chan = event_chan;
        r.freq = freq_hold;
        expected_outputs.push_back(r);
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned exp_val);
        mismatches++;
        if (mismatches <= SHOW_MAX)
            $display("error: result %0d %s got 0x%0h expected 0x%0h",
                     outputs_seen, what, got, exp_val);
    endtask

    // sample source: one pending item at a time, gap drawn as each item goes onto the bus
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                advance_detector(s_tdata, s_tuser);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    next_item = pending_samples.pop_front();
                    samples_sent++;
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.smp;
                    s_tuser  <= next_item.trough;
                    send_gap = quiet ? 0 : idle_len();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result sink with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_outputs.size() == 0)
                    flag_mismatch("transfer with nothing pending", m_tdata, 0);
                else
                begin
                    want = expected_outputs.pop_front();
                    if (m_tdata[0] !== want.peak)
                        flag_mismatch("peak_pulse", m_tdata[0], want.peak);
                    if (m_tdata[1] !== want.rel_pulse)
                        flag_mismatch("release_pulse", m_tdata[1], want.rel_pulse);
                    if (m_tdata[5:2] !== want.chan)
                        flag_mismatch("event_channel", m_tdata[5:2], want.chan);
                    if (m_tdata[25:6] !== want.freq)
                        flag_mismatch("frequency_estimate", m_tdata[25:6], want.freq);
                    outputs_seen++;
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (!quiet && $urandom_range(0, 2) == 0)
                stall_left = idle_len();
            m_tready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_sample(input logic [15:0] smp, input logic trough);
        sample_item_t it;
        it.smp = smp;
        it.trough = trough;
        pending_samples.push_back(it);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_MIN_INTERVAL: min_gap = value;
            CFG_EVENT_ENABLE: events_on = value[0];
            CFG_EVENT_LINE:   event_chan = value[3:0];
            CFG_SAMPLE_RATE:  rate_hz = value;
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // block is idle once every queued sample has come back as a result
    task automatic drain_block();
        @(posedge clk);
        while (pending_samples.size() != 0 || samples_sent != outputs_seen)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // rising and falling runs with random slope, some flat spots and some noise
    task automatic add_wave(input int count);
        int   level;
        int   dir;
        int   run_left;
        int   pick;
        logic trough;
        level = int'($urandom_range(0, 4000)) - 2000;
        dir = 1;
        run_left = 0;
        trough = 1'($urandom_range(0, 1));
        repeat (count)
        begin
            if (run_left == 0)
            begin
                dir = -dir;
                run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(1, 5);
                if ($urandom_range(0, 7) == 0)
                    trough = ~trough;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                queue_sample(16'($urandom), 1'($urandom_range(0, 1)));
            else
            begin
                if (pick >= 14)
                begin
                    level += dir * int'($urandom_range(1, 2500));
                    if (level > 32767)
                        level = 32767;
                    if (level < -32768)
                        level = -32768;
                    run_left--;
                end
                queue_sample(16'(level), trough);
            end
        end
    endtask

    initial
    begin
        logic [15:0] gap_val;
        logic [15:0] rate_val;
        int          n_items;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults: extremes of the sample, both modes, no peak possible
        queue_sample(16'h7FFF, 1'b0);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h8000, 1'b1);
        queue_sample(16'h7FFF, 1'b1);
        queue_sample(16'h0000, 1'b1);
        queue_sample(16'h0001, 1'b0);
        drain_block();

        write_reg(CFG_MIN_INTERVAL, 16'd0);
        write_reg(CFG_EVENT_ENABLE, 16'hFFFF);
        write_reg(CFG_EVENT_LINE, 16'hFFFF);
        write_reg(CFG_SAMPLE_RATE, 16'hFFFF);
        queue_sample(16'd0, 1'b0);
        queue_sample(16'd10, 1'b0);
        queue_sample(16'd5, 1'b0);
        queue_sample(16'd5, 1'b0);
        queue_sample(16'd7, 1'b0);
        queue_sample(16'd7, 1'b0);
        queue_sample(16'd3, 1'b0);
        queue_sample(16'h7FFF, 1'b0);
        // negated most negative sample sits above the largest positive one
        queue_sample(16'h8000, 1'b1);
        queue_sample(16'h8001, 1'b1);
        queue_sample(16'd100, 1'b1);
        queue_sample(16'd200, 1'b1);
        // counter passes the release count on a flat run after a rise, then a peak follows
        repeat (499) queue_sample(16'd0, 1'b0);
        queue_sample(16'd1, 1'b0);
        queue_sample(16'd0, 1'b0);
        drain_block();

        for (int ph = 0; ph < 7; ph++)
        begin
            n_items = 70;
            case (ph)
                0:
                begin
                    gap_val = 16'd0;
                    rate_val = 16'hFFFF;
                end
                2:
                begin
                    gap_val = 16'd520;
                    rate_val = 16'd1;
                    n_items = 600;
                end
                3:
                begin
                    gap_val = 16'($urandom_range(5, 40));
                    rate_val = 16'd0;
                end
                5:
                begin
                    gap_val = 16'($urandom_range(0, 12));
                    rate_val = 16'($urandom_range(1, 300));
                end
                default:
                begin
                    gap_val = 16'($urandom_range(0, 12));
                    rate_val = 16'($urandom_range(1, 65535));
                end
            endcase
            write_reg(CFG_MIN_INTERVAL, gap_val);
            write_reg(CFG_EVENT_ENABLE, {15'($urandom), 1'(!(ph == 1 || ph == 5))});
            write_reg(CFG_EVENT_LINE, (ph == 0) ? (16'($urandom) & 16'hFFF0) : 16'($urandom));
            write_reg(CFG_SAMPLE_RATE, rate_val);
            quiet = (ph == 4);
            add_wave(n_items);
            drain_block();
        end

        // largest minimum interval: no peak can be accepted
        write_reg(CFG_MIN_INTERVAL, 16'hFFFF);
        write_reg(CFG_EVENT_ENABLE, 16'd1);
        write_reg(CFG_EVENT_LINE, 16'd9);
        write_reg(CFG_SAMPLE_RATE, 16'd1);
        quiet = 1'b1;
        repeat (40) queue_sample(16'($urandom), 1'($urandom_range(0, 1)));
        queue_sample(16'd100, 1'b0);
        queue_sample(16'd50, 1'b0);
        queue_sample(16'd50, 1'b0);
        drain_block();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
